// File: hw/rtl/psfg_pkg.sv
// Package for the staggered field gather: widths, control word format,
// the microprogram and the window cube table. No dependencies.
package psfg_pkg;

    localparam int WT_W        = 16;
    localparam int FLD_W       = 16;
    localparam int WEIGHT_FRAC = 15;
    localparam int ACC_W       = 32;
    localparam int WIN_W       = 3;
    localparam int CNT_W       = 7;
    localparam int OPA_W       = 19;
    localparam int OPB_W       = FLD_W + 1;
    localparam int PROD_W      = OPA_W + OPB_W - 2 + 2;
    localparam int SUM_W       = PROD_W + 1;
    localparam int PC_W        = 5;
    localparam int N_COMP      = 6;

    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(2);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (WEIGHT_FRAC - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {W_NX, W_NY, W_NZ, W_SX, W_SY, W_SZ} wsel_t;
    typedef enum logic [2:0] {C_EX, C_EY, C_EZ, C_BX, C_BY, C_BZ} comp_t;
    typedef enum logic {A_WT, A_RND} a_src_t;
    typedef enum logic {B_WT, B_FLD} b_src_t;
    typedef enum logic {OP_NEXT, OP_END} seq_op_t;
    typedef enum logic {S_IDLE, S_RUN} seq_state_t;

    typedef struct packed {
        seq_op_t op;
        a_src_t  a_src;
        wsel_t   a_wt;
        b_src_t  b_src;
        wsel_t   b_wt;
        comp_t   fld;
        logic    acc_en;
        comp_t   acc_idx;
    } ctrl_word_t;

    typedef struct packed {
        logic       load;
        logic       go;
        logic       finish;
        ctrl_word_t cw;
    } seq_ctrl_t;

    typedef struct packed {
        logic reached;
        logic out_free;
    } dp_status_t;

    // weight selections per component: first z*y, then times x
    function automatic wsel_t wt_z(input comp_t k);
        wsel_t w;
        unique case (k)
            C_EX, C_EY, C_BZ: w = W_NZ;
            default:          w = W_SZ;
        endcase
        return w;
    endfunction

    function automatic wsel_t wt_y(input comp_t k);
        wsel_t w;
        unique case (k)
            C_EY, C_BX, C_BZ: w = W_SY;
            default:          w = W_NY;
        endcase
        return w;
    endfunction

    function automatic wsel_t wt_x(input comp_t k);
        wsel_t w;
        unique case (k)
            C_EX, C_BY, C_BZ: w = W_SX;
            default:          w = W_NX;
        endcase
        return w;
    endfunction

    function automatic ctrl_word_t cw_base();
        ctrl_word_t cw;
        cw.op      = OP_NEXT;
        cw.a_src   = A_WT;
        cw.a_wt    = W_NX;
        cw.b_src   = B_WT;
        cw.b_wt    = W_NX;
        cw.fld     = C_EX;
        cw.acc_en  = 1'b0;
        cw.acc_idx = C_EX;
        return cw;
    endfunction

    // z*y product, retiring the previous component's contribution
    function automatic ctrl_word_t cw_zy(input comp_t k, input logic acc_en,
                                         input comp_t acc_idx);
        ctrl_word_t cw;
        cw         = cw_base();
        cw.a_wt    = wt_z(k);
        cw.b_wt    = wt_y(k);
        cw.acc_en  = acc_en;
        cw.acc_idx = acc_idx;
        return cw;
    endfunction

    function automatic ctrl_word_t cw_x(input comp_t k);
        ctrl_word_t cw;
        cw       = cw_base();
        cw.a_src = A_RND;
        cw.b_wt  = wt_x(k);
        return cw;
    endfunction

    function automatic ctrl_word_t cw_fld(input comp_t k);
        ctrl_word_t cw;
        cw       = cw_base();
        cw.a_src = A_RND;
        cw.b_src = B_FLD;
        cw.fld   = k;
        return cw;
    endfunction

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = cw_base();
        unique case (pc)
            5'd0:  cw = cw_zy(C_EX, 1'b0, C_EX);
            5'd1:  cw = cw_x(C_EX);
            5'd2:  cw = cw_fld(C_EX);
            5'd3:  cw = cw_zy(C_EY, 1'b1, C_EX);
            5'd4:  cw = cw_x(C_EY);
            5'd5:  cw = cw_fld(C_EY);
            5'd6:  cw = cw_zy(C_EZ, 1'b1, C_EY);
            5'd7:  cw = cw_x(C_EZ);
            5'd8:  cw = cw_fld(C_EZ);
            5'd9:  cw = cw_zy(C_BX, 1'b1, C_EZ);
            5'd10: cw = cw_x(C_BX);
            5'd11: cw = cw_fld(C_BX);
            5'd12: cw = cw_zy(C_BY, 1'b1, C_BX);
            5'd13: cw = cw_x(C_BY);
            5'd14: cw = cw_fld(C_BY);
            5'd15: cw = cw_zy(C_BZ, 1'b1, C_BY);
            5'd16: cw = cw_x(C_BZ);
            5'd17: cw = cw_fld(C_BZ);
            5'd18:
            begin
                cw.acc_en  = 1'b1;
                cw.acc_idx = C_BZ;
            end
            default: cw.op = OP_END;
        endcase
        return cw;
    endfunction

    // points per particle; width 0 acts as 1, above 4 as 4
    function automatic logic [CNT_W-1:0] cube_target(input logic [WIN_W-1:0] win);
        logic [CNT_W-1:0] t;
        unique case (win)
            3'd0, 3'd1: t = CNT_W'(1);
            3'd2:       t = CNT_W'(8);
            3'd3:       t = CNT_W'(27);
            default:    t = CNT_W'(64);
        endcase
        return t;
    endfunction

endpackage

// File: hw/rtl/psfg_if.sv
// Valid/ready channels of the field gather: stencil point items in,
// gathered field items out. Depends on psfg_pkg for widths.
interface psfg_in_if;
    import psfg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [WT_W-1:0]         node_wt_x;
    logic [WT_W-1:0]         node_wt_y;
    logic [WT_W-1:0]         node_wt_z;
    logic [WT_W-1:0]         shift_wt_x;
    logic [WT_W-1:0]         shift_wt_y;
    logic [WT_W-1:0]         shift_wt_z;
    logic signed [FLD_W-1:0] grid_e_x;
    logic signed [FLD_W-1:0] grid_e_y;
    logic signed [FLD_W-1:0] grid_e_z;
    logic signed [FLD_W-1:0] grid_b_x;
    logic signed [FLD_W-1:0] grid_b_y;
    logic signed [FLD_W-1:0] grid_b_z;

    modport source (
        output valid, node_wt_x, node_wt_y, node_wt_z,
        output shift_wt_x, shift_wt_y, shift_wt_z,
        output grid_e_x, grid_e_y, grid_e_z, grid_b_x, grid_b_y, grid_b_z,
        input  ready
    );
    modport sink (
        input  valid, node_wt_x, node_wt_y, node_wt_z,
        input  shift_wt_x, shift_wt_y, shift_wt_z,
        input  grid_e_x, grid_e_y, grid_e_z, grid_b_x, grid_b_y, grid_b_z,
        output ready
    );
endinterface

interface psfg_out_if;
    import psfg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] e_out_x;
    logic signed [ACC_W-1:0] e_out_y;
    logic signed [ACC_W-1:0] e_out_z;
    logic signed [ACC_W-1:0] b_out_x;
    logic signed [ACC_W-1:0] b_out_y;
    logic signed [ACC_W-1:0] b_out_z;

    modport source (
        output valid, e_out_x, e_out_y, e_out_z, b_out_x, b_out_y, b_out_z,
        input  ready
    );
    modport sink (
        input  valid, e_out_x, e_out_y, e_out_z, b_out_x, b_out_y, b_out_z,
        output ready
    );
endinterface

// File: hw/rtl/psfg_seq.sv
// Microcode sequencer: step counter, program table lookup and the end
// jump. Depends on psfg_pkg.
module psfg_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psfg_pkg::dp_status_t status,
    output psfg_pkg::seq_ctrl_t  ctrl
);
    import psfg_pkg::*;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      cw;

    assign cw = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        in_ready    = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.go     = 1'b0;
        ctrl.finish = 1'b0;
        ctrl.cw     = cw;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_RUN;
                    pc_next    = '0;
                end
            end
            S_RUN:
            begin
                unique case (cw.op)
                    OP_NEXT:
                    begin
                        ctrl.go = 1'b1;
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_END:
                    begin
                        // hold here while a full result slot blocks the emit
                        if (!status.reached || status.out_free)
                        begin
                            ctrl.finish = 1'b1;
                            state_next  = S_IDLE;
                            pc_next     = '0;
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

// File: hw/rtl/psfg_dp.sv
// Datapath: operand latches, shared multiplier with rounding, six
// saturating accumulators, point counter and result register. Depends on
// psfg_pkg and psfg_if.
module psfg_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  psfg_pkg::seq_ctrl_t ctrl,
    output psfg_pkg::dp_status_t status,
    psfg_in_if.sink             point,
    psfg_out_if.source          result
);
    import psfg_pkg::*;

    logic [WIN_W-1:0]         win_reg;
    logic [WT_W-1:0]          nx_reg, ny_reg, nz_reg, sx_reg, sy_reg, sz_reg;
    logic signed [FLD_W-1:0]  fld_reg [N_COMP];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg [N_COMP];
    logic signed [ACC_W-1:0]  out_reg [N_COMP];
    logic                     out_valid_reg;
    logic [CNT_W-1:0]         pts_reg;

    logic [WT_W-1:0]          a_wt, b_wt;
    logic signed [FLD_W-1:0]  b_fld;
    logic [PROD_W-1:0]        rnd_sum;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [ACC_W-1:0]  acc_sel, acc_sat;
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         pts_p1;

    function automatic logic [WT_W-1:0] pick_wt(
        input wsel_t s, input logic [WT_W-1:0] nx, input logic [WT_W-1:0] ny,
        input logic [WT_W-1:0] nz, input logic [WT_W-1:0] sx,
        input logic [WT_W-1:0] sy, input logic [WT_W-1:0] sz);
        logic [WT_W-1:0] w;
        unique case (s)
            W_NX:    w = nx;
            W_NY:    w = ny;
            W_NZ:    w = nz;
            W_SX:    w = sx;
            W_SY:    w = sy;
            W_SZ:    w = sz;
            default: w = '0;
        endcase
        return w;
    endfunction

    assign a_wt = pick_wt(ctrl.cw.a_wt, nx_reg, ny_reg, nz_reg, sx_reg, sy_reg, sz_reg);
    assign b_wt = pick_wt(ctrl.cw.b_wt, nx_reg, ny_reg, nz_reg, sx_reg, sy_reg, sz_reg);

    always_comb
    begin
        unique case (ctrl.cw.fld)
            C_EX:    b_fld = fld_reg[0];
            C_EY:    b_fld = fld_reg[1];
            C_EZ:    b_fld = fld_reg[2];
            C_BX:    b_fld = fld_reg[3];
            C_BY:    b_fld = fld_reg[4];
            C_BZ:    b_fld = fld_reg[5];
            default: b_fld = '0;
        endcase
    end

    // round-to-nearest of the previous weight product, back to Q.15
    assign rnd_sum = prod_reg + ROUND_HALF;
    assign op_a = (ctrl.cw.a_src == A_RND) ? $signed(rnd_sum[WEIGHT_FRAC +: OPA_W])
                                           : $signed({{(OPA_W-WT_W){1'b0}}, a_wt});
    assign op_b = (ctrl.cw.b_src == B_FLD) ? $signed({b_fld[FLD_W-1], b_fld})
                                           : $signed({1'b0, b_wt});
    assign prod_full = op_a * op_b;

    always_comb
    begin
        unique case (ctrl.cw.acc_idx)
            C_EX:    acc_sel = acc_reg[0];
            C_EY:    acc_sel = acc_reg[1];
            C_EZ:    acc_sel = acc_reg[2];
            C_BX:    acc_sel = acc_reg[3];
            C_BY:    acc_sel = acc_reg[4];
            C_BZ:    acc_sel = acc_reg[5];
            default: acc_sel = '0;
        endcase
    end

    assign sum = {{(SUM_W-ACC_W){acc_sel[ACC_W-1]}}, acc_sel}
               + {prod_reg[PROD_W-1], prod_reg};

    always_comb
    begin
        if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1)
            acc_sat = sum[ACC_W-1:0];
        else if (sum[SUM_W-1])
            acc_sat = ACC_MIN;
        else
            acc_sat = ACC_MAX;
    end

    assign pts_p1          = pts_reg + CNT_W'(1);
    assign status.reached  = (pts_p1 >= cube_target(win_reg));
    assign status.out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= WIN_RESET;
        else if (cfg_we)
            win_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            nx_reg     <= point.node_wt_x;
            ny_reg     <= point.node_wt_y;
            nz_reg     <= point.node_wt_z;
            sx_reg     <= point.shift_wt_x;
            sy_reg     <= point.shift_wt_y;
            sz_reg     <= point.shift_wt_z;
            fld_reg[0] <= point.grid_e_x;
            fld_reg[1] <= point.grid_e_y;
            fld_reg[2] <= point.grid_e_z;
            fld_reg[3] <= point.grid_b_x;
            fld_reg[4] <= point.grid_b_y;
            fld_reg[5] <= point.grid_b_z;
        end
        if (ctrl.go)
            prod_reg <= prod_full;
        if (ctrl.finish && status.reached)
        begin
            for (int i = 0; i < N_COMP; i++)
                out_reg[i] <= acc_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_COMP; i++)
                acc_reg[i] <= '0;
            pts_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.go && ctrl.cw.acc_en)
                acc_reg[ctrl.cw.acc_idx] <= acc_sat;
            if (ctrl.finish)
            begin
                if (status.reached)
                begin
                    for (int i = 0; i < N_COMP; i++)
                        acc_reg[i] <= '0;
                    pts_reg <= '0;
                end
                else
                    pts_reg <= pts_p1;
            end
            if (ctrl.finish && status.reached)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.e_out_x = out_reg[0];
    assign result.e_out_y = out_reg[1];
    assign result.e_out_z = out_reg[2];
    assign result.b_out_x = out_reg[3];
    assign result.b_out_y = out_reg[4];
    assign result.b_out_z = out_reg[5];

endmodule

// File: hw/rtl/pic_staggered_field_gather.sv
// Staggered-grid field gather for one particle.
// Channels: point (sink) takes one stencil point item: nodal and shifted
// Q1.15 weights per axis plus the grid E and B vectors. result (source)
// gives the six saturated 32-bit sums once per particle.
// cfg_we/cfg_wdata write window_width (points per axis, 0 acts as 1,
// above 4 as 4); write only while the block is idle.
// Each point runs a 20-step microprogram on one shared 19x17 multiplier
// (three products per field component: z*y weight, times x weight,
// times field) with the accumulate of one component overlapped onto the
// next. Items are taken one at a time: accept, 19 work steps, end step.
// After window_width cubed points the result item is valid in the cycle
// after the end step; sums and point count clear then.
// Reset: accumulators and count clear, window_width is 2, no result held.
// If the result slot is still full when a particle completes, the
// sequencer waits at its end step and accepts no new point until the
// receiver takes the waiting item.
// Depends on psfg_pkg, psfg_if, psfg_seq, psfg_dp.
module pic_staggered_field_gather (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    psfg_in_if.sink    point,
    psfg_out_if.source result
);
    import psfg_pkg::*;

    seq_ctrl_t  ctrl;
    dp_status_t status;
    logic       in_ready;

    assign point.ready = in_ready;

    psfg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    psfg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .status    (status),
        .point     (point),
        .result    (result)
    );

endmodule

// File: sim/tb_pic_staggered_field_gather.sv
`timescale 1ns / 1ps
// Self-checking testbench for pic_staggered_field_gather: stencil point items
// are driven with random gaps, and results are checked against a bit-true predictor.
// Depends on psfg_pkg, psfg_if and the RTL of the block.
module tb_pic_staggered_field_gather;
    import psfg_pkg::*;

    localparam int ITEM_CYCLES = 21;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_WT        = 6;

    typedef struct {
        logic [WT_W-1:0]         wt[N_WT];     // indexed by wsel_t
        logic signed [FLD_W-1:0] fld[N_COMP];  // indexed by comp_t
    } stencil_pt_t;

    typedef struct {
        logic signed [ACC_W-1:0] comp[N_COMP];
    } field_sums_t;

    class gather_board;
        logic [WIN_W-1:0] window;
        longint           sums[N_COMP];
        int unsigned      points_seen;
        field_sums_t      expected_q[$];
        int unsigned      errors;
        string            comp_name[N_COMP] = '{"e_out_x", "e_out_y", "e_out_z",
                                                "b_out_x", "b_out_y", "b_out_z"};

        function new();
            window      = WIN_W'(2);
            points_seen = 0;
            errors      = 0;
            foreach (sums[k])
                sums[k] = 0;
        endfunction

        function void set_window(input logic [WIN_W-1:0] w);
            window = w;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint unsigned q15_mul(input longint unsigned a, input longint unsigned b);
            return (a * b + (64'd1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
        endfunction

        // z*y first, then x; n = nodal, s = half-cell shifted
        function longint unsigned stagger_wt(input stencil_pt_t p, input comp_t k);
            wsel_t wz;
            wsel_t wy;
            wsel_t wx;
            case (k)
                C_EX:
                begin
                    wz = W_NZ; wy = W_NY; wx = W_SX;
                end
                C_EY:
                begin
                    wz = W_NZ; wy = W_SY; wx = W_NX;
                end
                C_EZ:
                begin
                    wz = W_SZ; wy = W_NY; wx = W_NX;
                end
                C_BX:
                begin
                    wz = W_SZ; wy = W_SY; wx = W_NX;
                end
                C_BY:
                begin
                    wz = W_SZ; wy = W_NY; wx = W_SX;
                end
                default:
                begin
                    wz = W_NZ; wy = W_SY; wx = W_SX;
                end
            endcase
            return q15_mul(q15_mul(p.wt[wz], p.wt[wy]), p.wt[wx]);
        endfunction

        function void add_sat(input comp_t k, input longint f, input longint unsigned w);
            longint unsigned mag;
            longint unsigned prod;
            longint          c;
            longint          s;
            mag  = (f < 0) ? longint'(-f) : longint'(f);
            prod = mag * w;
            c    = (prod > (64'd1 << 33)) ? (64'sd1 <<< 33) : longint'(prod);
            if (f < 0)
                c = -c;
            s = sums[k] + c;
            if (s > longint'(ACC_MAX))
                s = longint'(ACC_MAX);
            if (s < longint'(ACC_MIN))
                s = longint'(ACC_MIN);
            sums[k] = s;
        endfunction

        function void note_point(input stencil_pt_t p);
            int unsigned eff;
            field_sums_t r;
            comp_t       k;
            eff = (window < 1) ? 1 : (window > 4) ? 4 : window;
            for (int i = 0; i < N_COMP; i++)
            begin
                k = comp_t'(i);
                add_sat(k, longint'(p.fld[k]), stagger_wt(p, k));
            end
            points_seen++;
            // a shrunk window emits on the next point once the count has passed it
            if (points_seen >= eff * eff * eff)
            begin
                foreach (sums[i])
                begin
                    r.comp[i] = sums[i][ACC_W-1:0];
                    sums[i]   = 0;
                end
                points_seen = 0;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(input field_sums_t r);
            field_sums_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected, e_out_x %0d", $time,
                         r.comp[C_EX]);
                return;
            end
            e = expected_q.pop_front();
            foreach (e.comp[i])
            begin
                if (e.comp[i] !== r.comp[i])
                begin
                    errors++;
                    $display("%0t: %s expected %0d actual %0d", $time, comp_name[i],
                             e.comp[i], r.comp[i]);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_wdata;
    bit               calm;
    int               sink_hold;
    int               quiet;
    gather_board      board = new();

    psfg_in_if  pt_if ();
    psfg_out_if res_if ();

    pic_staggered_field_gather i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .point     (pt_if),
        .result    (res_if)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stall bursts, none once the run is calm
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            res_if.ready <= 1'b0;
            sink_hold--;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            res_if.ready <= 1'b0;
            sink_hold = $urandom_range(1, 18) - 1;
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        field_sums_t r;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            r.comp[C_EX] = res_if.e_out_x;
            r.comp[C_EY] = res_if.e_out_y;
            r.comp[C_EZ] = res_if.e_out_z;
            r.comp[C_BX] = res_if.b_out_x;
            r.comp[C_BY] = res_if.b_out_y;
            r.comp[C_BZ] = res_if.b_out_z;
            board.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic stencil_pt_t uniform_pt(input logic [WT_W-1:0] w,
                                               input logic signed [FLD_W-1:0] f);
        stencil_pt_t p;
        foreach (p.wt[i])
            p.wt[i] = w;
        foreach (p.fld[i])
            p.fld[i] = f;
        return p;
    endfunction

    function automatic stencil_pt_t random_pt();
        stencil_pt_t p;
        bit          unit_wts;
        unit_wts = ($urandom_range(0, 9) == 0);
        foreach (p.wt[i])
        begin
            case ($urandom_range(0, 9))
                0:       p.wt[i] = '0;
                1:       p.wt[i] = WT_W'(32768);
                2:       p.wt[i] = WT_W'($urandom_range(0, 65535));
                default: p.wt[i] = WT_W'($urandom_range(0, 32768));
            endcase
            if (unit_wts)
                p.wt[i] = WT_W'(32768);
        end
        foreach (p.fld[i])
        begin
            case ($urandom_range(0, 9))
                0:       p.fld[i] = 16'sh8000;
                1:       p.fld[i] = 16'sh7fff;
                default: p.fld[i] = FLD_W'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic send_point(input stencil_pt_t p);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.node_wt_x  <= p.wt[W_NX];
        pt_if.node_wt_y  <= p.wt[W_NY];
        pt_if.node_wt_z  <= p.wt[W_NZ];
        pt_if.shift_wt_x <= p.wt[W_SX];
        pt_if.shift_wt_y <= p.wt[W_SY];
        pt_if.shift_wt_z <= p.wt[W_SZ];
        pt_if.grid_e_x   <= p.fld[C_EX];
        pt_if.grid_e_y   <= p.fld[C_EY];
        pt_if.grid_e_z   <= p.fld[C_EZ];
        pt_if.grid_b_x   <= p.fld[C_BX];
        pt_if.grid_b_y   <= p.fld[C_BY];
        pt_if.grid_b_z   <= p.fld[C_BZ];
        do
            @(posedge clk);
        while (!pt_if.ready);
        board.note_point(p);
    endtask

    // window writes only with the block idle; a partial particle may stay open
    task automatic set_window(input logic [WIN_W-1:0] w);
        pt_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_window(w);
    endtask

    initial
    begin
        stencil_pt_t      p;
        int unsigned      n;
        logic [WIN_W-1:0] win_plan[12];
        int unsigned      len_plan[12];

        win_plan = '{1, 2, 3, 5, 0, 2, 4, 1, 3, 7, 2, 1};
        len_plan = '{100, 160, 108, 64, 120, 96, 128, 80, 81, 64, 104, 50};

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        calm             = 1'b0;
        sink_hold        = 0;
        quiet            = 0;
        pt_if.valid      = 1'b0;
        pt_if.node_wt_x  = '0;
        pt_if.node_wt_y  = '0;
        pt_if.node_wt_z  = '0;
        pt_if.shift_wt_x = '0;
        pt_if.shift_wt_y = '0;
        pt_if.shift_wt_z = '0;
        pt_if.grid_e_x   = '0;
        pt_if.grid_e_y   = '0;
        pt_if.grid_e_z   = '0;
        pt_if.grid_b_x   = '0;
        pt_if.grid_b_y   = '0;
        pt_if.grid_b_z   = '0;
        res_if.ready     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of 2: drive into positive saturation, then back down from it
        send_point(uniform_pt('0, '0));
        repeat (3) send_point(uniform_pt(WT_W'(32768), 16'sh7fff));
        send_point(uniform_pt(WT_W'(32768), 16'sh8000));
        p.wt  = '{WT_W'(32768), WT_W'(24576), WT_W'(16384),
                  WT_W'(8192), WT_W'(4096), WT_W'(2048)};
        p.fld = '{16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000, 16'sd5000, -16'sd6000};
        send_point(p);
        send_point(uniform_pt(16'hffff, 16'sh8000));
        send_point(uniform_pt(16'hffff, 16'sh7fff));

        // window 0 behaves as 1: single-point particles, staggered selection
        set_window('0);
        send_point(p);
        send_point(uniform_pt(16'hffff, 16'sh8000));
        send_point(uniform_pt(16'h7fff, 16'sh5555));

        // shrink the window with a particle partly done
        set_window(WIN_W'(3));
        repeat (5) send_point(random_pt());
        set_window(WIN_W'(1));
        send_point(random_pt());

        foreach (win_plan[i])
        begin
            if (i == 11)
                calm = 1'b1;
            set_window(win_plan[i]);
            n = len_plan[i] + $urandom_range(0, 5);
            repeat (n) send_point(random_pt());
        end

        pt_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/psfg_pkg.sv
hw/rtl/psfg_if.sv
hw/rtl/psfg_seq.sv
hw/rtl/psfg_dp.sv
hw/rtl/pic_staggered_field_gather.sv
sim/tb_pic_staggered_field_gather.sv
